>>> hw/rtl/ipv6_pfx_pkg.sv
`default_nettype none
package ipv6_pfx_pkg;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDot   = 8'h2E;

  localparam logic [1:0] PhaseAddr = 2'd0;
  localparam logic [1:0] PhaseIpv4 = 2'd1;
  localparam logic [1:0] PhaseLen  = 2'd2;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  prefix_len;
    logic        parse_ok;
  } out_item_t;

  // Hex digit value, bit 4 set for a non-hex character.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ipv6_pfx_if.sv
`default_nettype none
interface ipv6_pfx_in_if;
  import ipv6_pfx_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ipv6_pfx_out_if;
  import ipv6_pfx_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ipv6_prefix_text_parser.sv
// IPv6 prefix text parser. Characters of a string such as "2001:db8::1/64" or
// "::ffff:1.2.3.4" enter on in_i, one per transfer, with is_last on the final
// one. While in_i is ready, a character is taken every cycle; the parse state
// is updated in the cycle of the transfer and a result for a final character
// lands in a one-deep output register the next cycle, then on out_o. Input
// stays ready while that register is empty or being drained. An error result
// carries zero address and length with parse_ok low. Strings longer than
// MAX_CHARS characters are errors.
`default_nettype none
module ipv6_prefix_text_parser
  import ipv6_pfx_pkg::*;
#(
  parameter int MAX_CHARS = 64
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  ipv6_pfx_in_if.sink    in_i,
  ipv6_pfx_out_if.source out_o
);

  localparam int CW = $clog2(MAX_CHARS + 1);

  logic [15:0] grp_q [8];
  logic [15:0] grp_d [8];
  logic [15:0] acc_q, acc_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [3:0]  gseen_q, gseen_d;
  logic [3:0]  gpos_q, gpos_d;
  logic        gap_q, gap_d;
  logic        pcol_q, pcol_d;
  logic [8:0]  oct_q, oct_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [7:0]  len_q, len_d;
  logic [1:0]  phase_q, phase_d;
  logic        err_q, err_d;
  logic [CW-1:0] ccnt_q, ccnt_d;

  logic      ovld_q;
  out_item_t odat_q, odat_d;
  logic      acc_in;

  assign in_i.ready = !ovld_q || out_o.ready;
  assign acc_in     = in_i.valid && in_i.ready;
  assign out_o.valid = ovld_q;
  assign out_o.data  = odat_q;

  always_comb begin
    logic [7:0]  c;
    logic [4:0]  h;
    logic [3:0]  dv;
    logic        isdig;
    logic [11:0] t12;
    logic [11:0] v4;
    logic [3:0]  n0, n1, n2;
    logic [2:0]  gi;
    logic [3:0]  nn;
    logic [15:0] fin [8];
    logic        ok;
    c = in_i.data.text_char;
    h = hex_val(c);
    isdig = (c >= 8'h30 && c <= 8'h39);
    dv = 4'(c - 8'h30);
    for (int i = 0; i < 8; i++) grp_d[i] = grp_q[i];
    acc_d = acc_q; dcnt_d = dcnt_q; gseen_d = gseen_q; gpos_d = gpos_q;
    gap_d = gap_q; pcol_d = pcol_q; oct_d = oct_q; oidx_d = oidx_q;
    len_d = len_q; phase_d = phase_q; err_d = err_q; ccnt_d = ccnt_q;
    odat_d = '0;
    t12 = '0; v4 = '0; gi = '0; nn = '0;
    n0 = acc_q[3:0]; n1 = acc_q[7:4]; n2 = acc_q[11:8];

    if (32'(ccnt_q) >= MAX_CHARS) err_d = 1'b1;
    else ccnt_d = ccnt_q + 1'b1;

    if (!err_d) begin
      unique case (phase_q)
        PhaseAddr: begin
          if (!h[4]) begin
            if ((pcol_q && gseen_q == 4'd0 && !gap_q) || dcnt_q >= 3'd4) err_d = 1'b1;
            else begin
              acc_d = {acc_q[11:0], h[3:0]};
              dcnt_d = dcnt_q + 3'd1;
              pcol_d = 1'b0;
            end
          end else if (c == CharColon) begin
            if (pcol_q) begin
              if (gap_q) err_d = 1'b1;
              else begin
                gap_d = 1'b1; gpos_d = gseen_q; pcol_d = 1'b0;
              end
            end else if (dcnt_q != 3'd0) begin
              if (gseen_q >= 4'd8) err_d = 1'b1;
              else begin
                grp_d[gseen_q[2:0]] = acc_q;
                gseen_d = gseen_q + 4'd1;
                acc_d = '0; dcnt_d = '0;
                pcol_d = 1'b1;
              end
            end else if (ccnt_q == CW'(0)) pcol_d = 1'b1;
            else err_d = 1'b1;
          end else if (c == CharDot) begin
            // reinterpret the pending hex digits as a decimal octet
            unique case (dcnt_q)
              3'd1: t12 = {8'd0, n0};
              3'd2: t12 = {8'd0, n1} * 12'd10 + {8'd0, n0};
              default: t12 = {8'd0, n2} * 12'd100 + {8'd0, n1} * 12'd10 + {8'd0, n0};
            endcase
            if (dcnt_q == 3'd0 || dcnt_q > 3'd3 || gseen_q > 4'd6 ||
                n0 > 4'd9 || (dcnt_q > 3'd1 && n1 > 4'd9) ||
                (dcnt_q > 3'd2 && n2 > 4'd9) ||
                (dcnt_q == 3'd2 && n1 == 4'd0) || (dcnt_q == 3'd3 && n2 == 4'd0) ||
                t12 > 12'd255) err_d = 1'b1;
            else begin
              grp_d[gseen_q[2:0]][15:8] = t12[7:0];
              phase_d = PhaseIpv4; oidx_d = 3'd1;
              oct_d = '0; dcnt_d = '0; acc_d = '0;
            end
          end else if (c == CharSlash) begin
            phase_d = PhaseLen;
            if (pcol_q) err_d = 1'b1;
            else begin
              if (dcnt_q != 3'd0) begin
                if (gseen_q >= 4'd8) err_d = 1'b1;
                else begin
                  grp_d[gseen_q[2:0]] = acc_q;
                  gseen_d = gseen_q + 4'd1;
                  acc_d = '0;
                end
              end
              if (!err_d && (gap_q ? (gseen_d > 4'd7) : (gseen_d != 4'd8))) err_d = 1'b1;
              dcnt_d = '0;
            end
          end else err_d = 1'b1;
        end
        PhaseIpv4: begin
          gi = 3'(gseen_q + 4'(oidx_q[2:1]));
          if (isdig) begin
            v4 = 12'(oct_q) * 12'd10 + {8'd0, dv};
            if ((dcnt_q != 3'd0 && oct_q == 9'd0) || v4 > 12'd255) err_d = 1'b1;
            else begin
              oct_d = v4[8:0]; dcnt_d = dcnt_q + 3'd1;
            end
          end else if (c == CharDot) begin
            if (dcnt_q == 3'd0 || oidx_q >= 3'd3) err_d = 1'b1;
            else begin
              if (oidx_q[0]) grp_d[gi][7:0] = oct_q[7:0];
              else grp_d[gi][15:8] = oct_q[7:0];
              oidx_d = oidx_q + 3'd1; oct_d = '0; dcnt_d = '0;
            end
          end else if (c == CharSlash) begin
            phase_d = PhaseLen;
            if (oidx_q != 3'd3 || dcnt_q == 3'd0) err_d = 1'b1;
            else begin
              grp_d[3'(gseen_q + 4'd1)][7:0] = oct_q[7:0];
              gseen_d = gseen_q + 4'd2;
              if (gap_q ? (gseen_d > 4'd7) : (gseen_d != 4'd8)) err_d = 1'b1;
              dcnt_d = '0;
            end
          end else err_d = 1'b1;
        end
        PhaseLen: begin
          v4 = 12'(len_q) * 12'd10 + {8'd0, dv};
          if (!isdig || v4 > 12'd128) err_d = 1'b1;
          else begin
            len_d = v4[7:0];
            if (dcnt_q < 3'd7) dcnt_d = dcnt_q + 3'd1;
          end
        end
        default: err_d = 1'b1;
      endcase
    end

    // end of string: close the address if no slash came, else require a length digit
    if (in_i.data.is_last && !err_d) begin
      if (phase_d == PhaseAddr) begin
        if (pcol_d) err_d = 1'b1;
        else if (dcnt_d != 3'd0) begin
          if (gseen_d >= 4'd8) err_d = 1'b1;
          else begin
            grp_d[gseen_d[2:0]] = acc_d;
            gseen_d = gseen_d + 4'd1;
          end
        end
        if (!err_d && (gap_d ? (gseen_d > 4'd7) : (gseen_d != 4'd8))) err_d = 1'b1;
      end else if (phase_d == PhaseIpv4) begin
        if (oidx_d != 3'd3 || dcnt_d == 3'd0) err_d = 1'b1;
        else begin
          grp_d[3'(gseen_d + 4'd1)][7:0] = oct_d[7:0];
          gseen_d = gseen_d + 4'd2;
          if (gap_d ? (gseen_d > 4'd7) : (gseen_d != 4'd8)) err_d = 1'b1;
        end
      end else if (dcnt_d == 3'd0) err_d = 1'b1;
    end

    ok = !err_d;
    nn = 4'((gseen_d - gpos_d) & 4'd7);
    for (int i = 0; i < 8; i++) begin
      fin[i] = grp_d[i];
      if (gap_d) begin
        fin[i] = '0;
        if (4'(i) < gpos_d) fin[i] = grp_d[i];
        else if (4'(i) >= 4'd8 - nn) fin[i] = grp_d[3'(gpos_d + 4'(i) + nn - 4'd8)];
      end
    end
    if (ok) begin
      odat_d.addr_high = {fin[0], fin[1], fin[2], fin[3]};
      odat_d.addr_low  = {fin[4], fin[5], fin[6], fin[7]};
      odat_d.prefix_len = (phase_d == PhaseLen) ? len_d : 8'd128;
      odat_d.parse_ok = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) grp_q[i] <= '0;
      acc_q <= '0; dcnt_q <= '0; gseen_q <= '0; gpos_q <= '0;
      gap_q <= 1'b0; pcol_q <= 1'b0; oct_q <= '0; oidx_q <= '0;
      len_q <= '0; phase_q <= PhaseAddr; err_q <= 1'b0; ccnt_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (acc_in && in_i.data.is_last) ovld_q <= 1'b1;
      else if (out_o.ready) ovld_q <= 1'b0;
      if (acc_in) begin
        if (in_i.data.is_last) begin
          // result out, parse state back to reset
          for (int i = 0; i < 8; i++) grp_q[i] <= '0;
          acc_q <= '0; dcnt_q <= '0; gseen_q <= '0; gpos_q <= '0;
          gap_q <= 1'b0; pcol_q <= 1'b0; oct_q <= '0; oidx_q <= '0;
          len_q <= '0; phase_q <= PhaseAddr; err_q <= 1'b0; ccnt_q <= '0;
        end else begin
          for (int i = 0; i < 8; i++) grp_q[i] <= grp_d[i];
          acc_q <= acc_d; dcnt_q <= dcnt_d; gseen_q <= gseen_d; gpos_q <= gpos_d;
          gap_q <= gap_d; pcol_q <= pcol_d; oct_q <= oct_d; oidx_q <= oidx_d;
          len_q <= len_d; phase_q <= phase_d; err_q <= err_d; ccnt_q <= ccnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && in_i.data.is_last) odat_q <= odat_d;
  end

endmodule
`default_nettype wire

>>> hw/rtl/ipv6_pfx_chk.sv
`default_nettype none
module ipv6_pfx_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_last_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [7:0]  out_len_i,
  input wire        out_ok_i,
  input wire [127:0] out_addr_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i))
    else $error("result without a final character");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i |-> out_len_i == 8'd0 && out_addr_i == '0)
    else $error("error result not cleared");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_len_i <= 8'd128)
    else $error("length out of range");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind ipv6_prefix_text_parser ipv6_pfx_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.data.is_last),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_len_i  (out_o.data.prefix_len),
  .out_ok_i   (out_o.data.parse_ok),
  .out_addr_i ({out_o.data.addr_high, out_o.data.addr_low})
);
`default_nettype wire

>>> tb/sv/ipv6_prefix_text_parser_checker.sv
module ipv6_prefix_text_parser_checker
  import ipv6_pfx_pkg::*;
#(
  parameter int MAX_CHARS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  in_item_t    in_data_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  out_item_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] grp_q [8];
  logic [15:0] acc_q;
  int unsigned ndig_q, ngrp_q, gap_pos_q, oct_q, oct_idx_q, len_q, phase_q, nchar_q;
  bit          gap_q, colon_q, err_q;
  out_item_t   addr_queue [$];

  function automatic int unsigned hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  task automatic clear_parse();
    foreach (grp_q[i]) grp_q[i] = '0;
    acc_q = '0;
    ndig_q = 0; ngrp_q = 0; gap_pos_q = 0; oct_q = 0; oct_idx_q = 0;
    len_q = 0; phase_q = PhaseAddr; nchar_q = 0;
    gap_q = 0; colon_q = 0; err_q = 0;
  endtask

  task automatic put_octet(int unsigned k, int unsigned v);
    int unsigned g;
    g = (ngrp_q + (k >> 1)) & 7;
    if (k & 1) grp_q[g][7:0] = v[7:0];
    else grp_q[g][15:8] = v[7:0];
  endtask

  task automatic close_group();
    if (ngrp_q >= 8) begin
      err_q = 1;
      return;
    end
    grp_q[ngrp_q & 7] = acc_q;
    ngrp_q++;
    acc_q = '0;
    ndig_q = 0;
  endtask

  task automatic finish_addr();
    if (phase_q == PhaseAddr) begin
      if (colon_q) begin
        err_q = 1;
        return;
      end
      if (ndig_q > 0) close_group();
      if (err_q) return;
    end else begin
      if (oct_idx_q != 3 || ndig_q == 0) begin
        err_q = 1;
        return;
      end
      put_octet(3, oct_q);
      ngrp_q += 2;
    end
    if (gap_q ? (ngrp_q > 7) : (ngrp_q != 8)) err_q = 1;
    ndig_q = 0;
  endtask

  task automatic enter_ipv4();
    int unsigned v, nib, top;
    v = 0;
    if (ndig_q == 0 || ndig_q > 3 || ngrp_q > 6) begin
      err_q = 1;
      return;
    end
    for (int i = ndig_q; i > 0; i--) begin
      nib = (acc_q >> (4 * (i - 1))) & 15;
      if (nib > 9) begin
        err_q = 1;
        return;
      end
      v = v * 10 + nib;
    end
    top = (acc_q >> (4 * (ndig_q - 1))) & 15;
    if ((ndig_q > 1 && top == 0) || v > 255) begin
      err_q = 1;
      return;
    end
    put_octet(0, v);
    phase_q = PhaseIpv4;
    oct_idx_q = 1;
    oct_q = 0;
    ndig_q = 0;
    acc_q = '0;
  endtask

  task automatic addr_char(logic [7:0] c);
    int unsigned h;
    h = hex_of(c);
    if (h < 16) begin
      if ((colon_q && ngrp_q == 0 && !gap_q) || ndig_q >= 4) begin
        err_q = 1;
        return;
      end
      acc_q = {acc_q[11:0], h[3:0]};
      ndig_q++;
      colon_q = 0;
    end else if (c == CharColon) begin
      if (colon_q) begin
        if (gap_q) err_q = 1;
        else begin
          gap_q = 1;
          gap_pos_q = ngrp_q;
          colon_q = 0;
        end
      end else if (ndig_q > 0) begin
        close_group();
        colon_q = 1;
      end else if (nchar_q == 1) colon_q = 1;
      else err_q = 1;
    end else if (c == CharDot) begin
      enter_ipv4();
    end else if (c == CharSlash) begin
      finish_addr();
      phase_q = PhaseLen;
    end else err_q = 1;
  endtask

  task automatic ipv4_char(logic [7:0] c);
    int unsigned v;
    if (c >= "0" && c <= "9") begin
      v = oct_q * 10 + (c - "0");
      if ((ndig_q > 0 && oct_q == 0) || v > 255) begin
        err_q = 1;
        return;
      end
      oct_q = v;
      ndig_q++;
    end else if (c == CharDot) begin
      if (ndig_q == 0 || oct_idx_q >= 3) begin
        err_q = 1;
        return;
      end
      put_octet(oct_idx_q, oct_q);
      oct_idx_q++;
      oct_q = 0;
      ndig_q = 0;
    end else if (c == CharSlash) begin
      finish_addr();
      phase_q = PhaseLen;
    end else err_q = 1;
  endtask

  task automatic len_char(logic [7:0] c);
    int unsigned v;
    if (c < "0" || c > "9") begin
      err_q = 1;
      return;
    end
    v = len_q * 10 + (c - "0");
    if (v > 128) begin
      err_q = 1;
      return;
    end
    len_q = v;
    if (ndig_q < 7) ndig_q++;
  endtask

  task automatic predict_char(in_item_t it);
    logic [15:0] fin [8];
    int unsigned n, plen;
    out_item_t   r;
    plen = 128;
    if (nchar_q >= MAX_CHARS) err_q = 1;
    else nchar_q++;
    if (!err_q) begin
      case (phase_q)
        PhaseAddr: addr_char(it.text_char);
        PhaseIpv4: ipv4_char(it.text_char);
        PhaseLen:  len_char(it.text_char);
        default:   err_q = 1;
      endcase
    end
    if (!it.is_last) return;
    if (!err_q) begin
      if (phase_q == PhaseAddr || phase_q == PhaseIpv4) finish_addr();
      else if (ndig_q == 0) err_q = 1;
      else plen = len_q;
    end
    r = '0;
    if (!err_q) begin
      foreach (fin[i]) fin[i] = grp_q[i];
      if (gap_q) begin
        n = (ngrp_q - gap_pos_q) & 7;
        foreach (fin[i]) fin[i] = '0;
        for (int i = 0; i < gap_pos_q && i < 8; i++) fin[i] = grp_q[i];
        for (int i = 0; i < n; i++) fin[(8 - n + i) & 7] = grp_q[(gap_pos_q + i) & 7];
      end
      r.addr_high = {fin[0], fin[1], fin[2], fin[3]};
      r.addr_low  = {fin[4], fin[5], fin[6], fin[7]};
      r.prefix_len = plen[7:0];
      r.parse_ok = 1'b1;
    end
    addr_queue.push_back(r);
    clear_parse();
  endtask

  assign pending_o = addr_queue.size();

  initial begin
    fail_count_o = 0;
    clear_parse();
  end

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (addr_queue.size() == 0) begin
          $error("unexpected result transfer");
          fail_count_o++;
        end else begin
          e = addr_queue.pop_front();
          if (out_data_i.addr_high !== e.addr_high) begin
            $error("addr_high exp %h got %h", e.addr_high, out_data_i.addr_high);
            fail_count_o++;
          end
          if (out_data_i.addr_low !== e.addr_low) begin
            $error("addr_low exp %h got %h", e.addr_low, out_data_i.addr_low);
            fail_count_o++;
          end
          if (out_data_i.prefix_len !== e.prefix_len) begin
            $error("prefix_len exp %0d got %0d", e.prefix_len, out_data_i.prefix_len);
            fail_count_o++;
          end
          if (out_data_i.parse_ok !== e.parse_ok) begin
            $error("parse_ok exp %0d got %0d", e.parse_ok, out_data_i.parse_ok);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_char(in_data_i);
    end
  end

endmodule

>>> tb/sv/ipv6_prefix_text_parser_tb.sv
module ipv6_prefix_text_parser_tb;
  import ipv6_pfx_pkg::*;

  localparam int WatchdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   chars_sent = 0;
  int   quiet_cycles = 0;

  ipv6_pfx_in_if  in_if ();
  ipv6_pfx_out_if out_if ();

  always #5 clk_i = ~clk_i;

  ipv6_prefix_text_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  ipv6_prefix_text_parser_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Random backpressure on the result side.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("ipv6_prefix_text_parser test failed");
      $finish;
    end
  end

  // Valid stays high after a transfer until the next character or an idle cycle.
  task automatic send_char(logic [7:0] c, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data.text_char <= c;
    in_if.data.is_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string hex_group();
    string s, d;
    int n;
    s = "";
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      d = $sformatf("%0h", $urandom_range(15));
      if ($urandom_range(1)) d = d.toupper();
      s = {s, d};
    end
    return s;
  endfunction

  function automatic string random_prefix();
    string s;
    int ng, gap, tail, r;
    s = "";
    tail = ($urandom_range(3) == 0);
    ng = tail ? 6 : 8;
    gap = $urandom_range(2) ? -1 : $urandom_range(ng);
    for (int i = 0; i < ng; i++) begin
      if (gap == i) begin
        s = {s, (i == 0) ? "::" : ":"};
        i += $urandom_range(ng - i);
        if (i >= ng) break;
      end else if (i > 0) s = {s, ":"};
      s = {s, hex_group()};
    end
    if (gap == ng) s = {s, "::"};
    if (tail) begin
      if (s.len() > 0 && s[s.len() - 1] != ":") s = {s, ":"};
      s = {s, $sformatf("%0d.%0d.%0d.%0d", $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255))};
    end
    if ($urandom_range(1)) begin
      r = $urandom_range(4) == 0 ? $urandom_range(255) : $urandom_range(128);
      s = {s, $sformatf("/%0d", r)};
    end
    // Corrupt a character now and then.
    if ($urandom_range(9) == 0 && s.len() > 0) begin
      r = $urandom_range(s.len() - 1);
      case ($urandom_range(3))
        0: s[r] = ":";
        1: s[r] = ".";
        2: s[r] = "/";
        default: s[r] = $urandom_range(255);
      endcase
      if (s[r] == 0) s[r] = "x";
    end
    return s;
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 80);
    for (int i = 0; i < n; i++) send_char($urandom_range(255), i == n - 1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int idle, int stall, int target);
    send_idle_pct = idle;
    sink_stall_pct = stall;
    while (chars_sent < target) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_text(random_prefix());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_text("::");
    send_text("::1");
    send_text("2001:db8::1/64");
    send_text("::ffff:1.2.3.4");
    send_text("FFFF:ffff:0:0:0:0:0:abcd/128");
    send_text("1:2:3:4:5:6:7:8/0");
    send_text("1::/000");
    send_text("12345::");
    send_text(":1::");
    send_text("1:::2");
    send_text("1::2::3");
    send_text("1:2/");
    send_text("1::/129");
    send_text("::1.2.3.04");
    send_text("::1.2.256.4");
    send_text("1::/6/4");
    send_text("1:2:3:4:5:6:7:8:9");
    send_text("1:");
    send_text("1:2:3:4:5:6:7:1.2.3.4");
    send_text("1::1:2:3:4:5:6:7");
    send_text("::::::::::::::::::::::::::::::::::::::::::::::::::::::::::::::::::1");
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    drain();
    run_phase(0, 0, 450);
    drain();
    run_phase(68, 0, 900);
    run_phase(0, 68, 1350);
    drain();
    run_phase(35, 35, 1800);
    run_phase(0, 0, 1900);
    drain();
    if (fail_count == 0) begin
      $display("ipv6_prefix_text_parser test passed");
    end else begin
      $display("ipv6_prefix_text_parser test failed");
    end
    $finish;
  end

endmodule
